FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // Bus operation codes; the command field uses the same encoding.
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_STOP  = 3'd4
  } op_t;

  // Configuration register indexes.
  localparam logic REG_ACK_TIMEOUT     = 1'b0;
  localparam logic REG_TICKS_PER_PHASE = 1'b1;

  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [15:0] TICKS_RESET       = 16'd1;

  // Phase at which a write starts waiting for the acknowledge.
  localparam logic [5:0] ACK_PHASE   = 6'd27;
  // Number of phases that carry the eight data bits of a write.
  localparam logic [5:0] WR_DATA_END = 6'd24;
  // Phase of a read at which the last bit is sampled.
  localparam logic [5:0] RD_LAST     = 6'd16;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Bit-level I2C master: command items load a bus operation, tick items step
// its line phases and every item returns the line levels and status.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   cmd       in          cmd_valid / cmd_stall  i2cm_pkg::cmd_t
//   res       out         res_valid / res_stall  i2cm_pkg::res_t
//   cfg       in          cfg_wen                cfg_addr, cfg_wdata
//
// Each item's result is registered in the output register, or in the skid
// register if the output is held; one item per cycle is sustained as it drains.
// The result path is a two-entry buffer (output register plus skid register);
// cmd_stall rises only when both hold an item, i.e. after the output stalls.
// Reset (rst, synchronous) returns the engine to idle with both lines released
// and the configuration at its reset values.
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_stall,
  input  wire i2cm_pkg::cmd_t  cmd,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output i2cm_pkg::res_t       res,
  input  wire logic            cfg_wen,
  input  wire logic            cfg_addr,
  input  wire logic [15:0]     cfg_wdata
);
  import i2cm_pkg::*;

  logic [7:0]  ack_timeout;
  logic [15:0] ticks_per_phase;

  op_t         current_op, current_op_next;
  logic [5:0]  phase_index, phase_index_next;
  logic [1:0]  bit_sub, bit_sub_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  ack_wait_count, ack_wait_count_next;
  logic [15:0] prescale_count, prescale_count_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        nack_flag, nack_flag_next;
  logic [7:0]  rx_last, rx_last_next;

  logic        accept;
  logic        fin;
  logic        rej;
  logic        is_cmd;
  logic [15:0] limit;
  logic [16:0] pre_inc;
  res_t        result;

  logic        skid_valid;
  res_t        skid;
  logic        out_free;

  assign cmd_stall = skid_valid;
  assign accept    = cmd_valid && !skid_valid;
  assign out_free  = !res_valid || !res_stall;

  assign is_cmd  = (cmd.action >= OP_START) && (cmd.action <= OP_STOP);
  assign limit   = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
  assign pre_inc = {1'b0, prescale_count} + 17'd1;

  always_comb begin
    current_op_next     = current_op;
    phase_index_next    = phase_index;
    bit_sub_next        = bit_sub;
    shift_byte_next     = shift_byte;
    ack_wait_count_next = ack_wait_count;
    prescale_count_next = prescale_count;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    nack_flag_next      = nack_flag;
    rx_last_next        = rx_last;
    fin                 = 1'b0;
    rej                 = 1'b0;

    if (is_cmd) begin
      if (current_op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        current_op_next     = op_t'(cmd.action);
        phase_index_next    = 6'd0;
        bit_sub_next        = 2'd0;
        prescale_count_next = 16'd0;
        ack_wait_count_next = 8'd0;
        shift_byte_next     = (op_t'(cmd.action) == OP_WRITE) ? cmd.tx_byte : 8'd0;
        if (op_t'(cmd.action) == OP_WRITE) begin
          nack_flag_next = 1'b0;
        end
      end
    end else if (current_op != OP_IDLE) begin
      if (current_op == OP_WRITE && phase_index >= ACK_PHASE) begin
        // The acknowledge wait runs on every tick, bypassing the prescaler.
        if (cmd.sda_in && ack_wait_count < ack_timeout) begin
          ack_wait_count_next = ack_wait_count + 8'd1;
        end else begin
          scl_level_next = 1'b0;
          nack_flag_next = cmd.sda_in;
          fin            = 1'b1;
        end
      end else if (pre_inc >= {1'b0, limit}) begin
        prescale_count_next = 16'd0;
        phase_index_next    = phase_index + 6'd1;
        bit_sub_next        = (bit_sub == 2'd2) ? 2'd0 : bit_sub + 2'd1;
        unique case (current_op)
          OP_START: begin
            unique case (phase_index)
              6'd0:    scl_level_next = 1'b0;
              6'd1:    sda_level_next = 1'b1;
              6'd2:    scl_level_next = 1'b1;
              6'd3:    sda_level_next = 1'b0;
              6'd4:    scl_level_next = 1'b0;
              default: begin
                sda_level_next = 1'b1;
                fin            = 1'b1;
              end
            endcase
          end
          OP_WRITE: begin
            // bit_sub tracks the phase within each three-phase data bit.
            if (phase_index < WR_DATA_END) begin
              unique case (bit_sub)
                2'd0: scl_level_next = 1'b0;
                2'd1: begin
                  sda_level_next  = shift_byte[7];
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                end
                default: scl_level_next = 1'b1;
              endcase
            end else if (phase_index == WR_DATA_END) begin
              scl_level_next = 1'b0;
            end else if (phase_index == WR_DATA_END + 6'd1) begin
              sda_level_next = 1'b1;
            end else begin
              scl_level_next = 1'b1;
            end
          end
          OP_READ: begin
            if (phase_index == 6'd0) begin
              scl_level_next = 1'b0;
              sda_level_next = 1'b1;
            end else if (phase_index[0]) begin
              scl_level_next = 1'b0;
            end else begin
              scl_level_next  = 1'b1;
              shift_byte_next = {shift_byte[6:0], cmd.sda_in};
              if (phase_index >= RD_LAST) begin
                rx_last_next = {shift_byte[6:0], cmd.sda_in};
                fin          = 1'b1;
              end
            end
          end
          default: begin
            unique case (phase_index)
              6'd0:    scl_level_next = 1'b0;
              6'd1:    sda_level_next = 1'b0;
              6'd2:    scl_level_next = 1'b1;
              default: begin
                sda_level_next = 1'b1;
                fin            = 1'b1;
              end
            endcase
          end
        endcase
      end else begin
        prescale_count_next = pre_inc[15:0];
      end
      if (fin) begin
        current_op_next     = OP_IDLE;
        phase_index_next    = 6'd0;
        prescale_count_next = 16'd0;
      end
    end

    result.scl_out  = scl_level_next;
    result.sda_out  = sda_level_next;
    result.busy_res = (current_op_next != OP_IDLE);
    result.done_res = fin;
    result.rx_byte  = rx_last_next;
    result.nack     = nack_flag_next;
    result.rejected = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout     <= ACK_TIMEOUT_RESET;
      ticks_per_phase <= TICKS_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_ACK_TIMEOUT:     ack_timeout     <= cfg_wdata[7:0];
        REG_TICKS_PER_PHASE: ticks_per_phase <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_op     <= OP_IDLE;
      phase_index    <= 6'd0;
      bit_sub        <= 2'd0;
      shift_byte     <= 8'd0;
      ack_wait_count <= 8'd0;
      prescale_count <= 16'd0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      nack_flag      <= 1'b0;
      rx_last        <= 8'd0;
    end else if (accept) begin
      current_op     <= current_op_next;
      phase_index    <= phase_index_next;
      bit_sub        <= bit_sub_next;
      shift_byte     <= shift_byte_next;
      ack_wait_count <= ack_wait_count_next;
      prescale_count <= prescale_count_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
      nack_flag      <= nack_flag_next;
      rx_last        <= rx_last_next;
    end
  end

  // Result buffer: the skid register only fills when the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        res <= skid;
      end else if (accept) begin
        res <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

endmodule

`default_nettype wire
